// ----- rtl/rbsi_pkg.sv -----
// Shared types and constants for the ray against box slab intersection block.
// Used by every module of the block; depends on nothing.

package rbsi_pkg;

   localparam int FracBits       = 16;
   localparam int DivSteps       = 16;
   localparam int DivBitsPerStep = 2;
   localparam int LaneLatency    = DivSteps + 2;
   localparam int Latency        = LaneLatency + 5;

   localparam logic [1:0] AxisX    = 2'd0;
   localparam logic [1:0] AxisY    = 2'd1;
   localparam logic [1:0] AxisZ    = 2'd2;
   localparam logic [1:0] AxisNone = 2'd3;

   localparam logic [2:0] CsrCenterX = 3'd0;
   localparam logic [2:0] CsrCenterY = 3'd1;
   localparam logic [2:0] CsrCenterZ = 3'd2;
   localparam logic [2:0] CsrHalfX   = 3'd3;
   localparam logic [2:0] CsrHalfY   = 3'd4;
   localparam logic [2:0] CsrHalfZ   = 3'd5;

   localparam logic [30:0] HalfReset = 31'd65536;

   localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
   localparam logic signed [31:0] SatMin = 32'sh8000_0000;

   typedef logic [2:0][31:0] vec3_type;
   typedef logic [2:0][30:0] half3_type;
   typedef logic [2:0][33:0] diff3_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [30:0]        max_distance;
   } req_type;

   typedef struct packed {
      logic               hit_found;
      logic [30:0]        distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [1:0]         normal_axis;
      logic               normal_negative;
   } rsp_type;

   typedef struct packed {
      vec3_type    org;
      vec3_type    dir;
      logic [30:0] max_distance;
      logic [2:0]  dir_zero;
      logic [2:0]  out_slab;
   } side_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] tmin;
      logic [1:0]  axis;
      logic        neg;
      vec3_type    org;
      vec3_type    dir;
   } hit_type;

endpackage

// ----- rtl/ray_box_slab_intersect.sv -----
// Top level of the ray against box slab intersection block.
// Depends on rbsi_pkg, rbsi_setup, rbsi_div, rbsi_select and rbsi_point.
//
// The box (center and half extents, Q16.16) is held in six registers on the
// APB-style port: center x, y, z at byte addresses 0, 4, 8 and half extents
// x, y, z at 12, 16, 20. Writes complete in the access cycle; pready is tied
// high and prdata returns the addressed register.
// A request is taken in any cycle in which start is high; busy is always low,
// so one ray enters per cycle. Each request yields exactly one response,
// shown for a single cycle with rsp_valid high. The depth is set mainly by
// the per-axis dividers, which resolve two quotient bits per stage over
// sixteen stages.
// The response has no backpressure and the pipeline never stalls.
// Reset clears all valid bits in the pipeline, so no response is produced for
// requests in flight, and loads the box registers with a box of half extent 1.0 at the origin.

module ray_box_slab_intersect (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rbsi_pkg::req_type req_data,
   output logic              rsp_valid,
   output rbsi_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   rbsi_pkg::vec3_type  center_ff;
   rbsi_pkg::half3_type half_ff;
   logic                req_valid_ff;
   rbsi_pkg::req_type   req_ff;
   logic                setup_valid;
   rbsi_pkg::side_type  setup_side;
   rbsi_pkg::diff3_type lo_diff;
   rbsi_pkg::diff3_type hi_diff;
   logic [5:0]          lane_valid;
   rbsi_pkg::vec3_type  t_lo;
   rbsi_pkg::vec3_type  t_hi;
   rbsi_pkg::side_type  side_dly_ff [rbsi_pkg::LaneLatency];
   logic                sel_valid;
   rbsi_pkg::hit_type   sel_hit;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= {3{rbsi_pkg::HalfReset}};
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            rbsi_pkg::CsrCenterX: center_ff[0] <= pwdata;
            rbsi_pkg::CsrCenterY: center_ff[1] <= pwdata;
            rbsi_pkg::CsrCenterZ: center_ff[2] <= pwdata;
            rbsi_pkg::CsrHalfX:   half_ff[0]   <= pwdata[30:0];
            rbsi_pkg::CsrHalfY:   half_ff[1]   <= pwdata[30:0];
            rbsi_pkg::CsrHalfZ:   half_ff[2]   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         rbsi_pkg::CsrCenterX: prdata = center_ff[0];
         rbsi_pkg::CsrCenterY: prdata = center_ff[1];
         rbsi_pkg::CsrCenterZ: prdata = center_ff[2];
         rbsi_pkg::CsrHalfX:   prdata = {1'b0, half_ff[0]};
         rbsi_pkg::CsrHalfY:   prdata = {1'b0, half_ff[1]};
         rbsi_pkg::CsrHalfZ:   prdata = {1'b0, half_ff[2]};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   rbsi_setup u_setup (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid_ff),
      .req          (req_ff),
      .center       (center_ff),
      .half         (half_ff),
      .out_valid_ff (setup_valid),
      .side_ff      (setup_side),
      .lo_diff_ff   (lo_diff),
      .hi_diff_ff   (hi_diff)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rbsi_div u_div_lo (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (setup_valid),
         .numer        (lo_diff[i]),
         .denom        (setup_side.dir[i]),
         .out_valid_ff (lane_valid[2*i]),
         .quot_ff      (t_lo[i])
      );
      rbsi_div u_div_hi (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (setup_valid),
         .numer        (hi_diff[i]),
         .denom        (setup_side.dir[i]),
         .out_valid_ff (lane_valid[2*i+1]),
         .quot_ff      (t_hi[i])
      );
   end

   always_ff @(posedge clock) begin
      side_dly_ff[0] <= setup_side;
      for (int k = 1; k < rbsi_pkg::LaneLatency; k++) begin
         side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   rbsi_select u_select (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (&lane_valid),
      .side         (side_dly_ff[rbsi_pkg::LaneLatency-1]),
      .t_lo         (t_lo),
      .t_hi         (t_hi),
      .out_valid_ff (sel_valid),
      .hit_ff       (sel_hit)
   );

   rbsi_point u_point (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sel_valid),
      .hit          (sel_hit),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_data)
   );

endmodule

// ----- rtl/rbsi_setup.sv -----
// Plane setup stage: box planes, plane minus origin per axis, and slab flags.
// Depends on rbsi_pkg.

module rbsi_setup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rbsi_pkg::req_type     req,
   input  rbsi_pkg::vec3_type    center,
   input  rbsi_pkg::half3_type   half,
   output logic                  out_valid_ff,
   output rbsi_pkg::side_type    side_ff,
   output rbsi_pkg::diff3_type   lo_diff_ff,
   output rbsi_pkg::diff3_type   hi_diff_ff
);

   rbsi_pkg::side_type  side_in;
   rbsi_pkg::diff3_type lo_diff_in;
   rbsi_pkg::diff3_type hi_diff_in;
   logic signed [33:0]  org_w [3];
   logic signed [33:0]  lo_w [3];
   logic signed [33:0]  hi_w [3];

   always_comb begin
      side_in.org[0]       = req.origin_x;
      side_in.org[1]       = req.origin_y;
      side_in.org[2]       = req.origin_z;
      side_in.dir[0]       = req.dir_x;
      side_in.dir[1]       = req.dir_y;
      side_in.dir[2]       = req.dir_z;
      side_in.max_distance = req.max_distance;
      for (int i = 0; i < 3; i++) begin
         org_w[i] = {{2{side_in.org[i][31]}}, side_in.org[i]};
         lo_w[i]  = $signed({{2{center[i][31]}}, center[i]}) - $signed({3'b000, half[i]});
         hi_w[i]  = $signed({{2{center[i][31]}}, center[i]}) + $signed({3'b000, half[i]});
         lo_diff_in[i]       = lo_w[i] - org_w[i];
         hi_diff_in[i]       = hi_w[i] - org_w[i];
         side_in.out_slab[i] = (org_w[i] < lo_w[i]) || (org_w[i] > hi_w[i]);
         side_in.dir_zero[i] = (side_in.dir[i] == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      lo_diff_ff <= lo_diff_in;
      hi_diff_ff <= hi_diff_in;
   end

endmodule

// ----- rtl/rbsi_div.sv -----
// Pipelined signed divider lane: (numer * 2^16) / denom, truncated toward zero
// and saturated to 32 bits, two quotient bits per stage. Depends on rbsi_pkg.

module rbsi_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [33:0] numer,
   input  logic signed [31:0] denom,
   output logic               out_valid_ff,
   output logic signed [31:0] quot_ff
);

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic [31:0] dabs;
      logic        neg;
      logic        ovf;
   } step_type;

   function automatic step_type div_step(input step_type s);
      step_type    r;
      logic [32:0] trial;
      r = s;
      for (int j = 0; j < rbsi_pkg::DivBitsPerStep; j++) begin
         trial = {r.rem, r.low[31]};
         r.low = {r.low[30:0], 1'b0};
         if (trial >= {1'b0, r.dabs}) begin
            trial = trial - {1'b0, r.dabs};
            r.quo = {r.quo[30:0], 1'b1};
         end else begin
            r.quo = {r.quo[30:0], 1'b0};
         end
         r.rem = trial[31:0];
      end
      return r;
   endfunction

   step_type           stage_in;
   step_type           stage_ff [rbsi_pkg::DivSteps + 1];
   logic               valid_ff [rbsi_pkg::DivSteps + 1];
   logic [33:0]        nabs_w;
   logic [48:0]        num_w;
   logic signed [31:0] quot_in;
   step_type           last_w;

   always_comb begin
      nabs_w         = numer[33] ? (34'd0 - numer) : numer;
      num_w          = {nabs_w[32:0], 16'd0};
      stage_in.rem   = {15'd0, num_w[48:32]};
      stage_in.low   = num_w[31:0];
      stage_in.quo   = 32'd0;
      stage_in.dabs  = denom[31] ? (32'd0 - denom) : denom;
      stage_in.neg   = numer[33] ^ denom[31];
      stage_in.ovf   = stage_in.rem >= stage_in.dabs;
   end

   always_comb begin
      last_w = stage_ff[rbsi_pkg::DivSteps];
      if (!last_w.neg) begin
         quot_in = (last_w.ovf || last_w.quo[31]) ? rbsi_pkg::SatMax : last_w.quo;
      end else begin
         quot_in = (last_w.ovf || last_w.quo > 32'h8000_0000) ? rbsi_pkg::SatMin
                                                             : 32'd0 - last_w.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= rbsi_pkg::DivSteps; k++) begin
            valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= rbsi_pkg::DivSteps; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[rbsi_pkg::DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= stage_in;
      for (int k = 1; k <= rbsi_pkg::DivSteps; k++) begin
         stage_ff[k] <= div_step(stage_ff[k-1]);
      end
      quot_ff <= quot_in;
   end

endmodule

// ----- rtl/rbsi_select.sv -----
// Slab combine stage: orders entry and exit per axis and folds the three axes
// into the entry distance, exit distance, entered face and hit flag. Depends on rbsi_pkg.

module rbsi_select (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rbsi_pkg::side_type side,
   input  rbsi_pkg::vec3_type t_lo,
   input  rbsi_pkg::vec3_type t_hi,
   output logic               out_valid_ff,
   output rbsi_pkg::hit_type  hit_ff
);

   rbsi_pkg::hit_type  hit_in;
   logic signed [31:0] tmin;
   logic signed [31:0] tmax;
   logic signed [31:0] t_enter;
   logic signed [31:0] t_exit;
   logic [1:0]         axis;
   logic               neg;
   logic               miss;

   always_comb begin
      tmin    = 32'sd0;
      tmax    = $signed({1'b0, side.max_distance});
      t_enter = 32'sd0;
      t_exit  = 32'sd0;
      axis    = rbsi_pkg::AxisNone;
      neg     = 1'b0;
      miss    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         t_enter = side.dir[i][31] ? t_hi[i] : t_lo[i];
         t_exit  = side.dir[i][31] ? t_lo[i] : t_hi[i];
         if (side.dir_zero[i]) begin
            miss = miss | side.out_slab[i];
         end else begin
            if (t_enter > tmin) begin
               tmin = t_enter;
               axis = 2'(i);
               neg  = !side.dir[i][31];
            end
            if (t_exit < tmax) begin
               tmax = t_exit;
            end
         end
      end
      hit_in.hit  = !miss && !(tmax < tmin);
      hit_in.tmin = tmin[30:0];
      hit_in.axis = axis;
      hit_in.neg  = neg;
      hit_in.org  = side.org;
      hit_in.dir  = side.dir;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

endmodule

// ----- rtl/rbsi_point.sv -----
// Hit point stages: direction times distance, then scale, add the origin,
// saturate and format the response. Depends on rbsi_pkg.

module rbsi_point (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rbsi_pkg::hit_type  hit,
   output logic               rsp_valid_ff,
   output rbsi_pkg::rsp_type  rsp_ff
);

   logic               mul_valid_ff;
   rbsi_pkg::hit_type  mul_hit_ff;
   logic signed [63:0] prod_in [3];
   logic signed [63:0] prod_ff [3];
   logic signed [63:0] adj_w [3];
   logic signed [63:0] sum_w [3];
   logic [31:0]        pt_w [3];
   rbsi_pkg::rsp_type  rsp_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed(hit.dir[i]) * $signed({1'b0, hit.tmin});
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         adj_w[i] = prod_ff[i] + (prod_ff[i][63] ? 64'sd65535 : 64'sd0);
         sum_w[i] = (adj_w[i] >>> rbsi_pkg::FracBits) + 64'($signed(mul_hit_ff.org[i]));
         if (sum_w[i] > 64'(rbsi_pkg::SatMax)) begin
            pt_w[i] = rbsi_pkg::SatMax;
         end else if (sum_w[i] < 64'(rbsi_pkg::SatMin)) begin
            pt_w[i] = rbsi_pkg::SatMin;
         end else begin
            pt_w[i] = sum_w[i][31:0];
         end
      end
      if (mul_hit_ff.hit) begin
         rsp_in.hit_found       = 1'b1;
         rsp_in.distance        = mul_hit_ff.tmin;
         rsp_in.point_x         = pt_w[0];
         rsp_in.point_y         = pt_w[1];
         rsp_in.point_z         = pt_w[2];
         rsp_in.normal_axis     = mul_hit_ff.axis;
         rsp_in.normal_negative = (mul_hit_ff.axis == rbsi_pkg::AxisNone) ? 1'b0
                                                                         : mul_hit_ff.neg;
      end else begin
         rsp_in.hit_found       = 1'b0;
         rsp_in.distance        = 31'd0;
         rsp_in.point_x         = 32'sd0;
         rsp_in.point_y         = 32'sd0;
         rsp_in.point_z         = 32'sd0;
         rsp_in.normal_axis     = rbsi_pkg::AxisNone;
         rsp_in.normal_negative = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_hit_ff <= hit;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/rbsi_check.sv -----
// Port-level checker for the ray against box slab intersection block, with
// its bind to the top level. Depends on rbsi_pkg and ray_box_slab_intersect.

module rbsi_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input rbsi_pkg::rsp_type rsp_data
);

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(rbsi_pkg::Latency) rsp_valid)
      else $error("request did not produce a response at the fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(rbsi_pkg::Latency) !rsp_valid)
      else $error("response without a matching request");

   a_miss_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_found |->
         rsp_data.distance == 31'd0 && rsp_data.point_x == 32'sd0 &&
         rsp_data.point_y == 32'sd0 && rsp_data.point_z == 32'sd0 &&
         rsp_data.normal_axis == rbsi_pkg::AxisNone && !rsp_data.normal_negative)
      else $error("miss response not cleared");

   a_face_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_found |->
         ((rsp_data.normal_axis == rbsi_pkg::AxisNone) ==
          (rsp_data.distance == 31'd0)) &&
         (rsp_data.normal_axis != rbsi_pkg::AxisNone || !rsp_data.normal_negative))
      else $error("entered face disagrees with hit distance");

endmodule

bind ray_box_slab_intersect rbsi_check u_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
